@@ rtl/core/tcw_pkg.sv @@
package tcw_pkg;

  // Default geometry of the character store
  localparam int RowsDef    = 50;
  localparam int ColumnsDef = 80;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // Character codes with special meaning
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Attribute after reset: green on black
  localparam logic [7:0] ATTR_RESET = 8'h02;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic read;        // read the requested cell
    logic put;         // write a character at the cursor, advance the column
    logic put_held;    // take the held character instead of the input byte
    logic hold_char;   // hold the input byte for a later put
    logic row_inc;     // move the cursor one row down
    logic col_zero;    // move the cursor to column zero
    logic home;        // move the cursor to row zero, column zero
    logic ptr_clear;   // restart the sweep pointer
    logic copy_step;   // read one cell one row below the pointer, queue its move
    logic blank_step;  // write a blank cell at the pointer
    logic blank_init;  // blank with the reset attribute
  } tcw_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic col_full;    // cursor column is past the last column
    logic row_last;    // cursor is on the bottom row
    logic copy_end;    // pointer is at the last cell that receives a moved cell
    logic ptr_end;     // pointer is at the last cell of the store
  } tcw_stat_t;

endpackage

@@ rtl/core/tcw_ctrl.sv @@
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] req_type_i,
  input  logic [7:0] char_code_i,
  input  tcw_stat_t  stat_i,
  output tcw_cmd_t   cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_PUT
  } state_e;

  state_e state_q, state_d;
  logic   put_pend_q, put_pend_d;
  logic   done_q, done_d;

  // Decide the next step and the commands for this cycle
  always_comb begin
    state_d    = state_q;
    put_pend_d = put_pend_q;
    done_d     = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.blank_step = 1'b1;
        cmd_o.blank_init = 1'b1;
        if (stat_i.ptr_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (req_type_i)
            REQ_WRITE: begin
              priority if (char_code_i == CH_NEWLINE) begin
                cmd_o.col_zero = 1'b1;
                put_pend_d     = 1'b0;
                if (stat_i.row_last) begin
                  cmd_o.ptr_clear = 1'b1;
                  state_d         = ST_COPY;
                end else begin
                  cmd_o.row_inc = 1'b1;
                  done_d        = 1'b1;
                end
              end else if (char_code_i == CH_RETURN) begin
                cmd_o.col_zero = 1'b1;
                done_d         = 1'b1;
              end else if (char_code_i == CH_NUL) begin
                done_d = 1'b1;
              end else if (stat_i.col_full) begin
                // Wrap first, then print at column zero
                cmd_o.hold_char = 1'b1;
                cmd_o.col_zero  = 1'b1;
                put_pend_d      = 1'b1;
                if (stat_i.row_last) begin
                  cmd_o.ptr_clear = 1'b1;
                  state_d         = ST_COPY;
                end else begin
                  cmd_o.row_inc = 1'b1;
                  state_d       = ST_PUT;
                end
              end else begin
                cmd_o.put = 1'b1;
                done_d    = 1'b1;
              end
            end
            REQ_READ: begin
              cmd_o.read = 1'b1;
              done_d     = 1'b1;
            end
            REQ_CLEAR: begin
              cmd_o.home      = 1'b1;
              cmd_o.ptr_clear = 1'b1;
              state_d         = ST_CLEAR;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.blank_step = 1'b1;
        if (stat_i.ptr_end) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (stat_i.copy_end) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Let the last moved cell land before blanking the bottom row
        state_d = ST_BLANK;
      end
      ST_BLANK: begin
        cmd_o.blank_step = 1'b1;
        if (stat_i.ptr_end) begin
          if (put_pend_q) begin
            state_d = ST_PUT;
          end else begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      ST_PUT: begin
        cmd_o.put      = 1'b1;
        cmd_o.put_held = 1'b1;
        put_pend_d     = 1'b0;
        state_d        = ST_IDLE;
        done_d         = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      put_pend_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      put_pend_q <= put_pend_d;
      done_q     <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

@@ rtl/core/tcw_datapath.sv @@
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int ROWS    = RowsDef,
  parameter int COLUMNS = ColumnsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tcw_cmd_t    cmd_i,
  output tcw_stat_t   stat_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  cell_row_i,
  input  logic [6:0]  cell_col_i,
  output logic [15:0] cell_value_o,
  output logic [5:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o
);

  localparam int Cells = ROWS * COLUMNS;
  localparam int AW    = $clog2(Cells);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLUMNS + 1);

  localparam logic [AW-1:0] ColStride = AW'(COLUMNS);
  localparam logic [AW-1:0] CopyLast  = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] CellLast  = AW'(Cells - 1);
  localparam logic [RW-1:0] RowLast   = RW'(ROWS - 1);
  localparam logic [CW-1:0] ColFull   = CW'(COLUMNS);

  logic [15:0]   mem [Cells];

  logic [7:0]    attr_q;
  logic [7:0]    char_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [AW-1:0] ptr_q;
  logic          mv_pend_q;
  logic [AW-1:0] mv_addr_q;
  logic [15:0]   rdata_q;
  logic          rd_sel_q;

  logic          req_in_range;
  logic [AW-1:0] req_addr;
  logic [AW-1:0] cur_addr;
  logic [7:0]    blank_attr;
  logic [7:0]    put_char;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;

  // Flat cell addresses
  assign req_addr = AW'(cell_row_i) * ColStride + AW'(cell_col_i);
  assign cur_addr = AW'(row_q) * ColStride + AW'(col_q);
  assign req_in_range = ({1'b0, cell_row_i} < 7'(ROWS)) &&
                        ({1'b0, cell_col_i} < 8'(COLUMNS));

  assign blank_attr = cmd_i.blank_init ? ATTR_RESET : attr_q;
  assign put_char   = cmd_i.put_held ? char_q : char_code_i;

  // Select the write: a moved cell, a blank cell or a printed character
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr_q, put_char};
    priority if (mv_pend_q) begin
      we    = 1'b1;
      waddr = mv_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.blank_step) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = {blank_attr, CH_SPACE};
    end else begin
      we    = cmd_i.put;
    end
  end

  // Select the read: a scroll source or the requested cell
  assign re    = cmd_i.copy_step || (cmd_i.read && req_in_range);
  assign raddr = cmd_i.copy_step ? (ptr_q + ColStride) : req_addr;

  // Character store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Hold a character that waits for a wrap
  always_ff @(posedge clk_i) begin
    if (cmd_i.hold_char) begin
      char_q <= char_code_i;
    end
  end

  // Attribute register, cursor, sweep pointer and pending move
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q    <= ATTR_RESET;
      row_q     <= '0;
      col_q     <= '0;
      ptr_q     <= '0;
      mv_pend_q <= 1'b0;
      mv_addr_q <= '0;
      rd_sel_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        attr_q <= cfg_wdata_i;
      end
      if (cmd_i.home) begin
        row_q <= '0;
      end else if (cmd_i.row_inc) begin
        row_q <= row_q + RW'(1);
      end
      if (cmd_i.home || cmd_i.col_zero) begin
        col_q <= '0;
      end else if (cmd_i.put) begin
        col_q <= col_q + CW'(1);
      end
      if (cmd_i.ptr_clear) begin
        ptr_q <= '0;
      end else if (cmd_i.copy_step || cmd_i.blank_step) begin
        ptr_q <= ptr_q + AW'(1);
      end
      mv_pend_q <= cmd_i.copy_step;
      mv_addr_q <= ptr_q;
      rd_sel_q  <= cmd_i.read && req_in_range;
    end
  end

  assign stat_o.col_full = (col_q == ColFull);
  assign stat_o.row_last = (row_q == RowLast);
  assign stat_o.copy_end = (ptr_q == CopyLast);
  assign stat_o.ptr_end  = (ptr_q == CellLast);

  assign cell_value_o = rd_sel_q ? rdata_q : 16'h0000;
  assign cursor_row_o = 6'(row_q);
  assign cursor_col_o = 7'(col_q);

endmodule

@@ rtl/core/text_console_writer.sv @@
// Text console writer. A request is taken at a clock edge where start is high and busy is low;
// its one result appears on cell_value_o, cursor_row_o and cursor_col_o for exactly one cycle
// with done_o high, in the cycle after the request finishes, and the receiver cannot stall it.
// A printed character, carriage return, NUL, unused request and cell read take one cycle, and
// busy stays low, so a new request may be taken every cycle. A printed character on a full row
// first wraps the cursor to column zero of the next row, then prints it with busy high. A
// newline on the bottom row scrolls: cells move one row up, then the bottom row is blanked;
// a character wrapping on the bottom row scrolls, then prints. A clear homes the cursor and
// blanks every cell. After reset the store is blanked. Sweeps hold busy high and move one cell
// per cycle through the single write port. The attribute register takes a write in any cycle.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int ROWS    = RowsDef,
  parameter int COLUMNS = ColumnsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  char_code_i,
  input  logic [5:0]  cell_row_i,
  input  logic [6:0]  cell_col_i,
  output logic        done_o,
  output logic [15:0] cell_value_o,
  output logic [5:0]  cursor_row_o,
  output logic [6:0]  cursor_col_o
);

  tcw_cmd_t  cmd;
  tcw_stat_t stat;

  // Sequence requests and sweeps
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy),
    .done_o      (done_o)
  );

  // Store, cursor and attribute
  tcw_datapath #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .char_code_i  (char_code_i),
    .cell_row_i   (cell_row_i),
    .cell_col_i   (cell_col_i),
    .cell_value_o (cell_value_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o)
  );

endmodule
